// File: rtl/rhse_pkg.sv
// ----------------------------------------------------------------------------
// rhse_pkg
// Shared constants, command codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rhse_pkg;

    // Payload widths
    localparam int HASH_W = 61;
    localparam int SYM_W  = 8;
    localparam int POS_W  = 13;
    localparam int CMD_W  = 2;

    // String capacity and the widths that follow from it
    localparam int MAX_LEN = 4096;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CMP_W   = (LEN_W > POS_W) ? LEN_W : POS_W;

    // Modulus 2^61-1 and the reset value of the base register
    localparam logic [HASH_W-1:0] MOD61      = {HASH_W{1'b1}};
    localparam logic [HASH_W-1:0] BASE_RESET = HASH_W'(131);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APP_HASH,
        ST_APP_POWER,
        ST_Q_CHECK,
        ST_Q_READ,
        ST_Q_MUL,
        ST_Q_OUT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic clear;
        logic start_h;
        logic start_p;
        logic start_q;
        logic cap_hnew;
        logic commit;
        logic rd_first;
        logic rd_second;
        logic cap_qres;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic range_err;
        logic mul_done;
    } t_dp_stat;

    // Final reduction of a value below twice the modulus.
    function automatic logic [HASH_W-1:0] fold62(input logic [HASH_W:0] s);
        logic [HASH_W:0] d;
        d = s - {1'b0, MOD61};
        return (s >= {1'b0, MOD61}) ? d[HASH_W-1:0] : s[HASH_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/rhse_ifs.sv
// ----------------------------------------------------------------------------
// rhse channel interfaces
// Valid/ready channels for commands, results and the base register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhse_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [rhse_pkg::CMD_W-1:0]  command;
    logic [rhse_pkg::SYM_W-1:0]  symbol;
    logic [rhse_pkg::POS_W-1:0]  left;
    logic [rhse_pkg::POS_W-1:0]  right;

    modport source(output valid, command, symbol, left, right, input ready);
    modport sink(input valid, command, symbol, left, right, output ready);
endinterface

interface rhse_res_if;
    logic                        valid;
    logic                        ready;
    logic [rhse_pkg::HASH_W-1:0] hash_value;
    logic                        range_error;

    modport source(output valid, hash_value, range_error, input ready);
    modport sink(input valid, hash_value, range_error, output ready);
endinterface

interface rhse_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [rhse_pkg::HASH_W-1:0] hash_base;

    modport source(output valid, hash_base, input ready);
    modport sink(input valid, hash_base, output ready);
endinterface

`default_nettype wire

// File: rtl/rolling_hash_substring_engine_unit.sv
// ----------------------------------------------------------------------------
// rolling_hash_substring_engine_unit
// Polynomial rolling hash modulo 2^61-1 over a stored byte string, with
// append, substring query and clear commands.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time. A clear, a dropped append (string
// full) or an unused code completes in the idle state; an append makes two
// passes through the shared modular multiplier (four 32x32 partial products,
// accumulate, fold); a query makes a range check with the first memory read,
// a second read of the one-port prefix memory, one multiplier pass and the
// load of the result register. A query with a bad range skips the second read
// and the multiplier. The result register lets the next command in while a
// result beat waits; a further query waits only for that register to empty.
// Position zero is held as a constant, so no memory clearing is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rolling_hash_substring_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rhse_cmd_if.sink    i_in,
    rhse_res_if.source  o_out,
    rhse_cfg_if.sink    i_cfg
);

    rhse_pkg::t_dp_cmd  dp_cmd;
    rhse_pkg::t_dp_stat dp_stat;
    logic               in_ready;
    logic               out_valid;

    // Base writes must come only while idle; the block itself does not enforce this, and the port is always open.
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

    rhse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.command),
        .o_in_ready   (in_ready),
        .o_out_valid  (out_valid),
        .i_out_ready  (o_out.ready),
        .i_stat       (dp_stat),
        .o_cmd        (dp_cmd)
    );

    rhse_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_symbol      (i_in.symbol),
        .i_left        (i_in.left),
        .i_right       (i_in.right),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_base    (i_cfg.hash_base),
        .o_hash_value  (o_out.hash_value),
        .o_range_error (o_out.range_error)
    );

endmodule

`default_nettype wire

// File: rtl/rhse_mulmod.sv
// ----------------------------------------------------------------------------
// rhse_mulmod
// Iterative multiplier modulo 2^61-1: four 32x32 partial products, one per
// cycle, accumulated into the full product and then folded.
// ----------------------------------------------------------------------------
`default_nettype none

module rhse_mulmod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rhse_pkg::HASH_W-1:0] i_a,
    input  logic [rhse_pkg::HASH_W-1:0] i_b,
    output logic                        o_done,
    output logic [rhse_pkg::HASH_W-1:0] o_res
);

    localparam int PROD_W = 2 * rhse_pkg::HASH_W;
    localparam int HALF_W = 32;
    localparam logic [2:0] LAST_PP  = 3'd3;
    localparam logic [2:0] LAST_ACC = 3'd4;
    localparam logic [2:0] REDUCE   = 3'd5;

    logic [rhse_pkg::HASH_W-1:0] r_a;
    logic [rhse_pkg::HASH_W-1:0] r_b;
    logic [PROD_W-1:0]           r_acc;
    logic [2*HALF_W-1:0]         r_pp;
    logic [1:0]                  r_pp_step;
    logic [2:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [rhse_pkg::HASH_W-1:0] r_res;

    logic [HALF_W-1:0]           op_x;
    logic [HALF_W-1:0]           op_y;
    logic [2*HALF_W-1:0]         prod;
    logic [PROD_W-1:0]           pp_shifted;
    logic [rhse_pkg::HASH_W:0]   fold_sum;

    // Step 0: low*low, 1: high(a)*low(b), 2: low(a)*high(b), 3: high*high.
    always_comb begin
        op_x = r_a[HALF_W-1:0];
        op_y = r_b[HALF_W-1:0];
        if (r_cnt[0]) begin
            op_x = HALF_W'(r_a[rhse_pkg::HASH_W-1:HALF_W]);
        end
        if (r_cnt[1]) begin
            op_y = HALF_W'(r_b[rhse_pkg::HASH_W-1:HALF_W]);
        end
    end

    assign prod = op_x * op_y;

    always_comb begin
        case (r_pp_step)
            2'd0:    pp_shifted = PROD_W'(r_pp);
            2'd1:    pp_shifted = PROD_W'(r_pp) << HALF_W;
            2'd2:    pp_shifted = PROD_W'(r_pp) << HALF_W;
            2'd3:    pp_shifted = PROD_W'(r_pp) << (2 * HALF_W);
            default: pp_shifted = '0;
        endcase
    end

    // The low half is at most the modulus and the high half below it, so their sum is below twice of it.
    assign fold_sum = {1'b0, r_acc[rhse_pkg::HASH_W-1:0]}
                    + {1'b0, r_acc[PROD_W-1:rhse_pkg::HASH_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == REDUCE) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= LAST_PP) begin
                r_pp      <= prod;
                r_pp_step <= r_cnt[1:0];
            end
            if (r_cnt >= 3'd1 && r_cnt <= LAST_ACC) begin
                r_acc <= r_acc + pp_shifted;
            end
            if (r_cnt == REDUCE) begin
                r_res <= rhse_pkg::fold62(fold_sum);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

// File: rtl/rhse_dp.sv
// ----------------------------------------------------------------------------
// rhse_dp
// Datapath: base register, item registers, prefix hash and power memories,
// the running tail hash and power, the shared modular multiplier and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhse_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rhse_pkg::t_dp_cmd           i_cmd,
    output rhse_pkg::t_dp_stat          o_stat,
    input  logic [rhse_pkg::SYM_W-1:0]  i_symbol,
    input  logic [rhse_pkg::POS_W-1:0]  i_left,
    input  logic [rhse_pkg::POS_W-1:0]  i_right,
    input  logic                        i_cfg_we,
    input  logic [rhse_pkg::HASH_W-1:0] i_cfg_base,
    output logic [rhse_pkg::HASH_W-1:0] o_hash_value,
    output logic                        o_range_error
);

    localparam int HW = rhse_pkg::HASH_W;
    localparam int CW = rhse_pkg::CMP_W;
    localparam int AW = rhse_pkg::ADDR_W;
    localparam int LW = rhse_pkg::LEN_W;

    logic [HW-1:0] mem_h [rhse_pkg::MAX_LEN];
    logic [HW-1:0] mem_p [rhse_pkg::MAX_LEN];

    logic [HW-1:0]                r_base;
    logic [rhse_pkg::SYM_W-1:0]   r_sym;
    logic [rhse_pkg::POS_W-1:0]   r_left;
    logic [rhse_pkg::POS_W-1:0]   r_right;
    logic [LW-1:0]                r_len;
    logic [HW-1:0]                r_last_hash;
    logic [HW-1:0]                r_last_power;
    logic [HW-1:0]                r_hnew;
    logic [HW-1:0]                r_h_rd;
    logic                         r_h_rd_zero;
    logic [HW-1:0]                r_p_rd;
    logic                         r_p_rd_zero;
    logic [HW-1:0]                r_qres;
    logic [HW-1:0]                r_out_hash;
    logic                         r_out_err;

    logic [HW-1:0]                base_eff;
    logic [HW-1:0]                h_rd_val;
    logic [HW-1:0]                p_rd_val;
    logic [rhse_pkg::POS_W-1:0]   h_idx;
    logic [rhse_pkg::POS_W-1:0]   p_idx;
    logic [AW-1:0]                h_addr;
    logic [AW-1:0]                p_addr;
    logic [AW-1:0]                wr_addr;
    logic                         range_err;
    logic                         mul_start;
    logic [HW-1:0]                mul_a;
    logic [HW-1:0]                mul_b;
    logic                         mul_done;
    logic [HW-1:0]                mul_res;

    // A base written as the modulus itself acts as zero.
    assign base_eff = (r_base == rhse_pkg::MOD61) ? '0 : r_base;

    // Position zero is never stored: its hash is zero and its power is one.
    assign h_rd_val = r_h_rd_zero ? '0 : r_h_rd;
    assign p_rd_val = r_p_rd_zero ? HW'(1) : r_p_rd;

    assign range_err = (CW'(r_left) > CW'(r_right)) || (CW'(r_right) > CW'(r_len));

    // Memory entry k holds position k+1.
    assign h_idx   = i_cmd.rd_second ? r_right : r_left;
    assign p_idx   = r_right - r_left;
    assign h_addr  = AW'(CW'(h_idx) - CW'(1));
    assign p_addr  = AW'(CW'(p_idx) - CW'(1));
    assign wr_addr = AW'(r_len);

    assign mul_start = i_cmd.start_h | i_cmd.start_p | i_cmd.start_q;
    assign mul_a     = i_cmd.start_h ? r_last_hash :
                       i_cmd.start_p ? r_last_power : h_rd_val;
    assign mul_b     = i_cmd.start_q ? p_rd_val : base_eff;

    rhse_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= rhse_pkg::BASE_RESET;
            r_len        <= '0;
            r_last_hash  <= '0;
            r_last_power <= HW'(1);
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_base;
            end
            if (i_cmd.clear) begin
                r_len        <= '0;
                r_last_hash  <= '0;
                r_last_power <= HW'(1);
            end else if (i_cmd.commit) begin
                r_len        <= r_len + LW'(1);
                r_last_hash  <= r_hnew;
                r_last_power <= mul_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_sym   <= i_symbol;
            r_left  <= i_left;
            r_right <= i_right;
        end
        if (i_cmd.cap_hnew) begin
            r_hnew <= rhse_pkg::fold62({1'b0, mul_res} + (HW + 1)'(r_sym));
        end
        if (i_cmd.cap_qres) begin
            r_qres <= rhse_pkg::fold62({1'b0, h_rd_val}
                                       + {1'b0, rhse_pkg::MOD61 - mul_res});
        end
        if (i_cmd.load_out) begin
            r_out_hash <= range_err ? '0 : r_qres;
            r_out_err  <= range_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            mem_h[wr_addr] <= r_hnew;
        end
        if (i_cmd.rd_first || i_cmd.rd_second) begin
            r_h_rd      <= mem_h[h_addr];
            r_h_rd_zero <= (h_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            mem_p[wr_addr] <= mul_res;
        end
        if (i_cmd.rd_first) begin
            r_p_rd      <= mem_p[p_addr];
            r_p_rd_zero <= (p_idx == '0);
        end
    end

    assign o_stat.full      = (r_len == LW'(rhse_pkg::MAX_LEN));
    assign o_stat.range_err = range_err;
    assign o_stat.mul_done  = mul_done;

    assign o_hash_value  = r_out_hash;
    assign o_range_error = r_out_err;

endmodule

`default_nettype wire

// File: rtl/rhse_ctrl.sv
// ----------------------------------------------------------------------------
// rhse_ctrl
// Controller: sequences appends and queries through the datapath and owns
// the valid flag of the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rhse_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [rhse_pkg::CMD_W-1:0] i_in_command,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  rhse_pkg::t_dp_stat         i_stat,
    output rhse_pkg::t_dp_cmd          o_cmd
);

    rhse_pkg::t_state r_state;
    rhse_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             accept;
    logic             out_free;

    assign accept   = i_in_valid && (r_state == rhse_pkg::ST_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rhse_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_in_command == rhse_pkg::CMD_APPEND && !i_stat.full) begin
                        n_state = rhse_pkg::ST_APP_HASH;
                    end else if (i_in_command == rhse_pkg::CMD_QUERY) begin
                        n_state = rhse_pkg::ST_Q_CHECK;
                    end
                end
            end
            rhse_pkg::ST_APP_HASH: begin
                if (i_stat.mul_done) begin
                    n_state = rhse_pkg::ST_APP_POWER;
                end
            end
            rhse_pkg::ST_APP_POWER: begin
                if (i_stat.mul_done) begin
                    n_state = rhse_pkg::ST_IDLE;
                end
            end
            rhse_pkg::ST_Q_CHECK: begin
                n_state = i_stat.range_err ? rhse_pkg::ST_Q_OUT : rhse_pkg::ST_Q_READ;
            end
            rhse_pkg::ST_Q_READ: begin
                n_state = rhse_pkg::ST_Q_MUL;
            end
            rhse_pkg::ST_Q_MUL: begin
                if (i_stat.mul_done) begin
                    n_state = rhse_pkg::ST_Q_OUT;
                end
            end
            rhse_pkg::ST_Q_OUT: begin
                if (out_free) begin
                    n_state = rhse_pkg::ST_IDLE;
                end
            end
            default: n_state = rhse_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rhse_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = accept;
                o_cmd.clear     = accept && (i_in_command == rhse_pkg::CMD_CLEAR);
                // The tail hash is already at hand, so the first product starts now.
                o_cmd.start_h   = accept && (i_in_command == rhse_pkg::CMD_APPEND)
                                  && !i_stat.full;
            end
            rhse_pkg::ST_APP_HASH: begin
                o_cmd.cap_hnew = i_stat.mul_done;
                o_cmd.start_p  = i_stat.mul_done;
            end
            rhse_pkg::ST_APP_POWER: begin
                o_cmd.commit = i_stat.mul_done;
            end
            rhse_pkg::ST_Q_CHECK: begin
                o_cmd.rd_first = 1'b1;
            end
            rhse_pkg::ST_Q_READ: begin
                o_cmd.start_q   = 1'b1;
                o_cmd.rd_second = 1'b1;
            end
            rhse_pkg::ST_Q_MUL: begin
                o_cmd.cap_qres = i_stat.mul_done;
            end
            rhse_pkg::ST_Q_OUT: begin
                o_cmd.load_out = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rhse_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: tb/rolling_hash_substring_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// rolling_hash_substring_engine_unit_tb
// Self-checking bench for the rolling hash engine. Command beats are driven
// with random gaps, result beats are taken with random stalls, and each
// result is compared against an independent modulo 2^61-1 prediction held in
// a small scoreboard class. Several base settings are used, among them the
// smallest and largest legal bases and the all-ones value, and one phase
// fills the string to capacity.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct packed {
    logic [rhse_pkg::HASH_W-1:0] hash_value;
    logic                        range_error;
} t_substring_result;

class t_substring_hash_scoreboard;
    logic [rhse_pkg::HASH_W-1:0] prefix_h [0:rhse_pkg::MAX_LEN];
    logic [rhse_pkg::HASH_W-1:0] base_pow [0:rhse_pkg::MAX_LEN];
    logic [rhse_pkg::HASH_W-1:0] base_reg;
    int                          str_len;
    int                          errors;
    t_substring_result           expected_hashes[$];

    function new();
        prefix_h[0] = '0;
        base_pow[0] = rhse_pkg::HASH_W'(1);
        base_reg    = rhse_pkg::BASE_RESET;
        str_len     = 0;
        errors      = 0;
    endfunction

    // Reduces a value below 2^63 modulo 2^61-1.
    function logic [rhse_pkg::HASH_W-1:0] reduce(input logic [62:0] v);
        logic [rhse_pkg::HASH_W:0] t;
        t = {1'b0, v[rhse_pkg::HASH_W-1:0]}
            + (rhse_pkg::HASH_W+1)'(v[62:rhse_pkg::HASH_W]);
        if (t >= {1'b0, rhse_pkg::MOD61})
            t = t - {1'b0, rhse_pkg::MOD61};
        return t[rhse_pkg::HASH_W-1:0];
    endfunction

    function logic [rhse_pkg::HASH_W-1:0] mul_mod(input logic [rhse_pkg::HASH_W-1:0] a,
                                                  input logic [rhse_pkg::HASH_W-1:0] b);
        logic [2*rhse_pkg::HASH_W-1:0] p;
        p = (2*rhse_pkg::HASH_W)'(a) * (2*rhse_pkg::HASH_W)'(b);
        return reduce(63'(p[rhse_pkg::HASH_W-1:0])
                      + 63'(p[2*rhse_pkg::HASH_W-1:rhse_pkg::HASH_W]));
    endfunction

    function void set_base(input logic [rhse_pkg::HASH_W-1:0] v);
        base_reg = v;
    endfunction

    function int length();
        return str_len;
    endfunction

    function int pending();
        return expected_hashes.size();
    endfunction

    function void note_command(input logic [rhse_pkg::CMD_W-1:0] cmd,
                               input logic [rhse_pkg::SYM_W-1:0] sym,
                               input logic [rhse_pkg::POS_W-1:0] lft,
                               input logic [rhse_pkg::POS_W-1:0] rgt);
        logic [rhse_pkg::HASH_W-1:0] b;
        logic [rhse_pkg::HASH_W-1:0] sub;
        t_substring_result res;
        b = reduce(63'(base_reg));
        case (cmd)
            rhse_pkg::CMD_APPEND: begin
                if (str_len < rhse_pkg::MAX_LEN) begin
                    prefix_h[str_len+1] = reduce(63'(mul_mod(prefix_h[str_len], b))
                                                 + 63'(sym));
                    base_pow[str_len+1] = mul_mod(base_pow[str_len], b);
                    str_len++;
                end
            end
            rhse_pkg::CMD_QUERY: begin
                if (lft > rgt || int'(rgt) > str_len) begin
                    res.hash_value  = '0;
                    res.range_error = 1'b1;
                end else begin
                    sub = mul_mod(prefix_h[lft], base_pow[rgt-lft]);
                    res.hash_value  = reduce(63'(prefix_h[rgt])
                                             + 63'(rhse_pkg::MOD61 - sub));
                    res.range_error = 1'b0;
                end
                expected_hashes = {expected_hashes, res};
            end
            rhse_pkg::CMD_CLEAR: str_len = 0;
            default: ;
        endcase
    endfunction

    function void check_result(input logic [rhse_pkg::HASH_W-1:0] hash_value,
                               input logic range_error);
        t_substring_result exp_res;
        if (expected_hashes.size() == 0) begin
            $error("unexpected result beat: hash_value %h, range_error %b",
                   hash_value, range_error);
            errors++;
            return;
        end
        exp_res = expected_hashes.pop_front();
        if (hash_value !== exp_res.hash_value) begin
            $error("hash_value mismatch: expected %h, actual %h",
                   exp_res.hash_value, hash_value);
            errors++;
        end
        if (range_error !== exp_res.range_error) begin
            $error("range_error mismatch: expected %b, actual %b",
                   exp_res.range_error, range_error);
            errors++;
        end
    endfunction
endclass

module rolling_hash_substring_engine_unit_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 320;

    localparam logic [rhse_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;
    int   idle_cycles;

    t_substring_hash_scoreboard sb = new();

    rhse_cmd_if cmd_ch();
    rhse_res_if res_ch();
    rhse_cfg_if cfg_ch();

    rolling_hash_substring_engine_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Mostly short gaps, a few long ones, none at all in a calm stretch.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [rhse_pkg::HASH_W-1:0] random_base();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return rhse_pkg::HASH_W'(raw % 64'(rhse_pkg::MOD61 - rhse_pkg::HASH_W'(129)))
               + rhse_pkg::HASH_W'(129);
    endfunction

    task automatic send_cmd(input logic [rhse_pkg::CMD_W-1:0] cmd,
                            input logic [rhse_pkg::SYM_W-1:0] sym,
                            input logic [rhse_pkg::POS_W-1:0] lft,
                            input logic [rhse_pkg::POS_W-1:0] rgt);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.symbol  <= sym;
        cmd_ch.left    <= lft;
        cmd_ch.right   <= rgt;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(cmd, sym, lft, rgt);
    endtask

    task automatic send_append();
        send_cmd(rhse_pkg::CMD_APPEND, rhse_pkg::SYM_W'($urandom_range(0, 255)),
                 rhse_pkg::POS_W'($urandom_range(0, rhse_pkg::MAX_LEN)),
                 rhse_pkg::POS_W'($urandom_range(0, rhse_pkg::MAX_LEN)));
    endtask

    // Most queries fall inside the stored string; the rest are arbitrary ranges.
    task automatic send_random_query();
        int len;
        int lft;
        int rgt;
        len = sb.length();
        if ($urandom_range(0, 99) < 80) begin
            rgt = $urandom_range(0, len);
            lft = $urandom_range(0, rgt);
        end else begin
            rgt = $urandom_range(0, rhse_pkg::MAX_LEN);
            lft = $urandom_range(0, rhse_pkg::MAX_LEN);
        end
        send_cmd(rhse_pkg::CMD_QUERY, rhse_pkg::SYM_W'($urandom_range(0, 255)),
                 rhse_pkg::POS_W'(lft), rhse_pkg::POS_W'(rgt));
    endtask

    // An append gives no result, so the block may still be busy once the last
    // expected result has arrived; a further settling wait covers that.
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [rhse_pkg::HASH_W-1:0] value);
        drain();
        cfg_ch.valid     <= 1'b1;
        cfg_ch.hash_base <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_base(value);
    endtask

    // Result side: take every beat offered, with random stalls on ready.
    initial begin
        int stall;
        stall = 0;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.hash_value, res_ch.range_error);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                stall--;
            end else begin
                res_ch.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        int roll;
        logic [rhse_pkg::HASH_W-1:0] base;

        i_rst_n          <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.command   <= rhse_pkg::CMD_APPEND;
        cmd_ch.symbol    <= '0;
        cmd_ch.left      <= '0;
        cmd_ch.right     <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.hash_base <= '0;
        calm = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset base.
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd0, 13'd0);
        send_cmd(rhse_pkg::CMD_QUERY, 8'hFF, 13'd0, 13'd1);
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, rhse_pkg::POS_W'(rhse_pkg::MAX_LEN),
                 rhse_pkg::POS_W'(rhse_pkg::MAX_LEN));
        send_cmd(rhse_pkg::CMD_APPEND, 8'h00, 13'd0, 13'd0);
        send_cmd(rhse_pkg::CMD_APPEND, 8'hFF, rhse_pkg::POS_W'(rhse_pkg::MAX_LEN),
                 rhse_pkg::POS_W'(rhse_pkg::MAX_LEN));
        send_cmd(rhse_pkg::CMD_APPEND, 8'hA5, 13'd7, 13'd2);
        send_cmd(CMD_UNUSED, 8'hFF, rhse_pkg::POS_W'(rhse_pkg::MAX_LEN), 13'd1);
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd0, 13'd3);
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd1, 13'd3);
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd2, 13'd1);
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd3, 13'd3);
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd0, 13'd4);
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, rhse_pkg::POS_W'(rhse_pkg::MAX_LEN), 13'd0);
        send_cmd(rhse_pkg::CMD_CLEAR, 8'hFF, rhse_pkg::POS_W'(rhse_pkg::MAX_LEN),
                 rhse_pkg::POS_W'(rhse_pkg::MAX_LEN));
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd0, 13'd1);
        send_cmd(rhse_pkg::CMD_APPEND, 8'h5A, 13'd0, 13'd0);
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd0, 13'd1);

        // Random phases, each under its own base; the string carries over.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: base = rhse_pkg::HASH_W'(129);
                1: base = rhse_pkg::MOD61 - rhse_pkg::HASH_W'(1);
                2: base = rhse_pkg::MOD61;
                default: base = random_base();
            endcase
            write_base(base);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (sent % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                roll = $urandom_range(0, 99);
                if (roll < 55) begin
                    send_append();
                    sent++;
                end else if (roll < 90) begin
                    send_random_query();
                    sent++;
                end else if (roll < 93) begin
                    send_cmd(rhse_pkg::CMD_CLEAR, rhse_pkg::SYM_W'($urandom_range(0, 255)),
                             rhse_pkg::POS_W'($urandom_range(0, rhse_pkg::MAX_LEN)),
                             rhse_pkg::POS_W'($urandom_range(0, rhse_pkg::MAX_LEN)));
                    sent++;
                end else begin
                    send_cmd(CMD_UNUSED, rhse_pkg::SYM_W'($urandom_range(0, 255)),
                             rhse_pkg::POS_W'($urandom_range(0, rhse_pkg::MAX_LEN)),
                             rhse_pkg::POS_W'($urandom_range(0, rhse_pkg::MAX_LEN)));
                end
            end
        end

        // Fill to capacity; the last few appends must be dropped.
        write_base(random_base());
        send_cmd(rhse_pkg::CMD_CLEAR, 8'h00, 13'd0, 13'd0);
        for (int i = 0; i < rhse_pkg::MAX_LEN + 8; i++) begin
            if (i % 512 == 0)
                calm = ($urandom_range(0, 2) == 0);
            send_append();
            if ($urandom_range(0, 31) == 0)
                send_random_query();
        end
        calm = 1'b0;
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd0, rhse_pkg::POS_W'(rhse_pkg::MAX_LEN));
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, rhse_pkg::POS_W'(rhse_pkg::MAX_LEN),
                 rhse_pkg::POS_W'(rhse_pkg::MAX_LEN));
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd1, rhse_pkg::POS_W'(rhse_pkg::MAX_LEN));
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, rhse_pkg::POS_W'(rhse_pkg::MAX_LEN),
                 rhse_pkg::POS_W'(rhse_pkg::MAX_LEN - 1));
        for (int i = 0; i < 16; i++)
            send_random_query();
        send_cmd(rhse_pkg::CMD_CLEAR, 8'h00, 13'd0, 13'd0);
        send_append();
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd0, 13'd1);
        send_cmd(rhse_pkg::CMD_QUERY, 8'h00, 13'd0, rhse_pkg::POS_W'(rhse_pkg::MAX_LEN));

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: rolling_hash_substring_engine_unit.f
rtl/rhse_pkg.sv
rtl/rhse_ifs.sv
rtl/rhse_mulmod.sv
rtl/rhse_dp.sv
rtl/rhse_ctrl.sv
rtl/rolling_hash_substring_engine_unit.sv
tb/rolling_hash_substring_engine_unit_tb.sv
